@@ hdl/tsts_pkg.sv @@
package tsts_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int IDX_W = $clog2(TASK_SLOTS);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] ST_RUNNING       = 3'd0;
  localparam logic [2:0] ST_INTERRUPTIBLE = 3'd1;

  localparam logic [31:0] ALARM_BIT   = 32'h0000_2000;
  localparam logic [31:0] UNBLOCKABLE = 32'h0004_0100;
  localparam logic [9:0]  IDLE_COUNT  = 10'd15;
  localparam logic [7:0]  IDLE_PRIO   = 8'd15;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  task_index;
    logic        present;
    logic [2:0]  run_state;
    logic [9:0]  counter_value;
    logic [7:0]  priority_value;
    logic [31:0] alarm_time;
    logic [31:0] signal_bits;
    logic [31:0] blocked_bits;
    logic [31:0] now;
    logic        from_user;
  } in_t;

  typedef struct packed {
    logic [5:0]  current_task;
    logic        switched;
    logic        ran_schedule;
    logic        read_present;
    logic [2:0]  read_state;
    logic [9:0]  read_counter;
    logic [7:0]  read_priority;
    logic [31:0] read_alarm;
    logic [31:0] read_signals;
  } out_t;

  typedef struct packed {
    logic        present;
    logic [2:0]  run_state;
    logic [9:0]  counter;
    logic [7:0]  prio;
    logic [31:0] alarm;
    logic [31:0] signals;
    logic [31:0] blocked;
  } slot_t;

endpackage

@@ hdl/time_slice_task_scheduler.sv @@
// A write's result is registered in the cycle after it is accepted; a read
// waits in S_RDW and a tick without schedule in S_TKW before its result is
// registered. A schedule pass scans slots TASK_SLOTS-1..1 through the slot
// memory, one slot per cycle, once, plus a second sweep when counters are
// recalculated; a tick starts the pass from S_TKW. One item in flight at a time.
// Reset is synchronous active low; afterwards a clearing pass writes the reset
// slot contents to all TASK_SLOTS slots while no input is accepted.
module time_slice_task_scheduler (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tsts_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tsts_pkg::out_t out_data
);
  import tsts_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_TKW  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_RECL = 3'd5;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TASK_SLOTS - 1);
  localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);

  slot_t mem [TASK_SLOTS];
  slot_t mem_q;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  slot_t            mem_wd;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] proc_r, proc_nxt;
  logic             iss_r, iss_nxt, pend_r, pend_nxt;
  logic             any_r, any_nxt;
  logic [9:0]       best_r, best_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [IDX_W-1:0] run_r, run_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             user_r, user_nxt;
  logic             rdok_r, rdok_nxt;
  logic             ov_r, ov_nxt;
  out_t             od_r, od_nxt;

  logic             accept;
  logic             idx_ok;
  slot_t            upd;
  logic [9:0]       dec;
  logic             cand;

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign accept    = in_valid && !in_stall;
  assign idx_ok    = {1'b0, in_data.task_index} < 7'(TASK_SLOTS);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    proc_nxt  = proc_r;
    iss_nxt   = iss_r;
    pend_nxt  = 1'b0;
    any_nxt   = any_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    run_nxt   = run_r;
    now_nxt   = now_r;
    user_nxt  = user_r;
    rdok_nxt  = rdok_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = proc_r;
    mem_ra    = addr_r;
    mem_wd    = mem_q;
    upd       = mem_q;
    dec       = mem_q.counter - 10'd1;
    cand      = 1'b0;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = addr_r;
        mem_wd = '0;
        if (addr_r == '0) begin
          mem_wd.present = 1'b1;
          mem_wd.counter = IDLE_COUNT;
          mem_wd.prio    = IDLE_PRIO;
        end
        addr_nxt = addr_r + ONE;
        if (addr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          now_nxt  = in_data.now;
          user_nxt = in_data.from_user;
          od_nxt   = '0;
          od_nxt.current_task = 6'(run_r);
          case (in_data.op)
            OP_WRITE: begin
              mem_we = idx_ok;
              mem_wa = IDX_W'(in_data.task_index);
              mem_wd.present = in_data.present;
              mem_wd.run_state = in_data.run_state;
              mem_wd.counter = in_data.counter_value;
              mem_wd.prio = in_data.priority_value;
              mem_wd.alarm = in_data.alarm_time;
              mem_wd.signals = in_data.signal_bits;
              mem_wd.blocked = in_data.blocked_bits;
              ov_nxt = 1'b1;
            end
            OP_SCHED: begin
              state_nxt = S_SCAN;
              addr_nxt  = LAST;
              iss_nxt   = 1'b1;
              any_nxt   = 1'b0;
            end
            OP_TICK: begin
              mem_re    = 1'b1;
              mem_ra    = run_r;
              state_nxt = S_TKW;
            end
            default: begin
              mem_re    = 1'b1;
              mem_ra    = IDX_W'(in_data.task_index);
              rdok_nxt  = idx_ok;
              state_nxt = S_RDW;
            end
          endcase
        end
      end
      S_RDW: begin
        if (rdok_r) begin
          od_nxt.read_present  = mem_q.present;
          od_nxt.read_state    = mem_q.run_state;
          od_nxt.read_counter  = mem_q.counter;
          od_nxt.read_priority = mem_q.prio;
          od_nxt.read_alarm    = mem_q.alarm;
          od_nxt.read_signals  = mem_q.signals;
        end
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_TKW: begin
        mem_we = 1'b1;
        mem_wa = run_r;
        if (mem_q.counter > 10'd1) begin
          mem_wd.counter = dec;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_wd.counter = '0;
          if (user_r) begin
            state_nxt = S_SCAN;
            addr_nxt  = LAST;
            iss_nxt   = 1'b1;
            any_nxt   = 1'b0;
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN, S_RECL: begin
        if (iss_r) begin
          mem_re   = 1'b1;
          proc_nxt = addr_r;
          pend_nxt = 1'b1;
          addr_nxt = addr_r - ONE;
          iss_nxt  = (addr_r != ONE);
        end
        if (pend_r) begin
          if (mem_q.present) begin
            if (state_r == S_SCAN) begin
              if (mem_q.alarm != '0 && mem_q.alarm < now_r) begin
                upd.signals = mem_q.signals | ALARM_BIT;
                upd.alarm   = '0;
              end
              if ((upd.signals & ~(mem_q.blocked & ~UNBLOCKABLE)) != '0 &&
                  mem_q.run_state == ST_INTERRUPTIBLE) begin
                upd.run_state = ST_RUNNING;
              end
            end else begin
              upd.counter = {1'b0, mem_q.counter[9:1]} + {2'b00, mem_q.prio};
            end
          end
          mem_we = 1'b1;
          mem_wd = upd;
          cand = upd.present && upd.run_state == ST_RUNNING;
          if (cand && (!any_r || upd.counter > best_r)) begin
            any_nxt  = 1'b1;
            best_nxt = upd.counter;
            pick_nxt = proc_r;
          end
        end
        if (!iss_r && !pend_r) begin
          if (state_r == S_SCAN && any_r && best_r == '0) begin
            state_nxt = S_RECL;
            addr_nxt  = LAST;
            iss_nxt   = 1'b1;
            any_nxt   = 1'b0;
          end else begin
            run_nxt = (any_r && best_r != '0) ? pick_r : '0;
            od_nxt.current_task = 6'(run_nxt);
            od_nxt.switched     = run_nxt != run_r;
            od_nxt.ran_schedule = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      addr_r  <= '0;
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
      any_r   <= 1'b0;
      run_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= pend_nxt;
      any_r   <= any_nxt;
      run_r   <= run_nxt;
      ov_r    <= ov_nxt;
    end
    proc_r <= proc_nxt;
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    now_r  <= now_nxt;
    user_r <= user_nxt;
    rdok_r <= rdok_nxt;
    od_r   <= od_nxt;
  end

endmodule

@@ test/time_slice_task_scheduler_tb.sv @@
`timescale 1ns / 1ps

module time_slice_task_scheduler_tb;
  import tsts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  time_slice_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // shadow task table
  slot_t      tbl[TASK_SLOTS];
  logic [5:0] cur_task;

  in_t  pending_ops[$];
  out_t expected_results[$];
  int   error_count;
  int   idle_cycles;
  int   in_gap;
  int   out_gap;

  task automatic report(string what, out_t got, out_t want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  function automatic logic [5:0] best_runnable(output logic [9:0] best, output bit any);
    logic [5:0] pick;
    pick = 0;
    best = 0;
    any  = 0;
    for (int k = TASK_SLOTS - 1; k >= 1; k--) begin
      if (tbl[k].present && tbl[k].run_state == ST_RUNNING) begin
        if (!any || tbl[k].counter > best) begin
          best = tbl[k].counter;
          pick = k[5:0];
          any  = 1;
        end
      end
    end
    return pick;
  endfunction

  function automatic bit schedule_pass(logic [31:0] now);
    logic [5:0] pick;
    logic [5:0] prev;
    logic [9:0] best;
    bit any;
    for (int k = TASK_SLOTS - 1; k >= 1; k--) begin
      if (tbl[k].present) begin
        if (tbl[k].alarm != 0 && tbl[k].alarm < now) begin
          tbl[k].signals |= ALARM_BIT;
          tbl[k].alarm = 0;
        end
        if ((tbl[k].signals & ~(tbl[k].blocked & ~UNBLOCKABLE)) != 0 &&
            tbl[k].run_state == ST_INTERRUPTIBLE)
          tbl[k].run_state = ST_RUNNING;
      end
    end
    pick = best_runnable(best, any);
    if (any && best == 0) begin
      for (int k = TASK_SLOTS - 1; k >= 1; k--)
        if (tbl[k].present)
          tbl[k].counter = (tbl[k].counter >> 1) + 10'(tbl[k].prio);
      pick = best_runnable(best, any);
      if (!any || best == 0) pick = 0;
    end else if (!any) begin
      pick = 0;
    end
    prev = cur_task;
    cur_task = pick;
    return prev != pick;
  endfunction

  function automatic out_t predict_result(in_t op_in);
    out_t r;
    r = '0;
    case (op_in.op)
      OP_WRITE: begin
        tbl[op_in.task_index] = '{op_in.present, op_in.run_state, op_in.counter_value,
                                  op_in.priority_value, op_in.alarm_time,
                                  op_in.signal_bits, op_in.blocked_bits};
      end
      OP_SCHED: begin
        r.switched = schedule_pass(op_in.now);
        r.ran_schedule = 1'b1;
      end
      OP_TICK: begin
        if (tbl[cur_task].counter > 1) begin
          tbl[cur_task].counter--;
        end else begin
          tbl[cur_task].counter = 0;
          if (op_in.from_user) begin
            r.switched = schedule_pass(op_in.now);
            r.ran_schedule = 1'b1;
          end
        end
      end
      default: begin
        r.read_present  = tbl[op_in.task_index].present;
        r.read_state    = tbl[op_in.task_index].run_state;
        r.read_counter  = tbl[op_in.task_index].counter;
        r.read_priority = tbl[op_in.task_index].prio;
        r.read_alarm    = tbl[op_in.task_index].alarm;
        r.read_signals  = tbl[op_in.task_index].signals;
      end
    endcase
    r.current_task = cur_task;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'(1) << $urandom_range(0, 31);
      3: return 32'($urandom_range(1, 400));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t make_op(logic [1:0] op, logic [5:0] idx);
    in_t t;
    t = '0;
    t.op             = op;
    t.task_index     = idx;
    t.present        = ($urandom_range(0, 3) != 0);
    t.run_state      = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
    t.counter_value  = ($urandom_range(0, 2) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 4));
    t.priority_value = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 6));
    t.alarm_time     = ($urandom_range(0, 1) == 0) ? 32'h0 : rand_word();
    t.signal_bits    = ($urandom_range(0, 1) == 0) ? 32'h0 : rand_word();
    t.blocked_bits   = rand_word();
    t.now            = rand_word();
    t.from_user      = 1'($urandom_range(0, 1));
    return t;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_t t;
    for (int i = 0; i < TASK_SLOTS; i++) tbl[i] = '0;
    tbl[0].present = 1;
    tbl[0].counter = IDLE_COUNT;
    tbl[0].prio    = IDLE_PRIO;
    cur_task = 0;

    // directed: extremes, idle fallback, unblockable signals, bad run state
    pending_ops.push_back(make_op(OP_SCHED, 6'd0));
    t = make_op(OP_READ, 6'd63); pending_ops.push_back(t);
    t = '1; t.op = OP_WRITE; t.run_state = 3'd7; pending_ops.push_back(t);
    t = '1; t.op = OP_READ; pending_ops.push_back(t);
    t = '0; t.op = OP_WRITE; t.task_index = 6'd5; t.present = 1'b1;
    t.run_state = ST_INTERRUPTIBLE; t.priority_value = 8'd3;
    t.signal_bits = 32'h0000_0100; t.blocked_bits = 32'hFFFF_FFFF;
    pending_ops.push_back(t);
    t = '0; t.op = OP_WRITE; t.task_index = 6'd9; t.present = 1'b1;
    t.run_state = ST_INTERRUPTIBLE; t.counter_value = 10'd1023;
    t.priority_value = 8'd255; t.alarm_time = 32'd10; t.blocked_bits = 32'hFFFF_FFFF;
    pending_ops.push_back(t);
    t = '0; t.op = OP_SCHED; t.now = 32'd11; pending_ops.push_back(t);
    t = '0; t.op = OP_READ; t.task_index = 6'd9; pending_ops.push_back(t);
    t = '0; t.op = OP_WRITE; t.task_index = 6'd9; pending_ops.push_back(t);
    t = '0; t.op = OP_SCHED; t.now = 32'hFFFF_FFFF; pending_ops.push_back(t);
    for (int i = 0; i < 4; i++) begin
      t = '0; t.op = OP_TICK; t.from_user = i[0]; pending_ops.push_back(t);
    end
    t = '0; t.op = OP_WRITE; t.task_index = 6'd5; t.present = 1'b1; pending_ops.push_back(t);
    t = '0; t.op = OP_SCHED; pending_ops.push_back(t);
    t = '0; t.op = OP_TICK; t.from_user = 1'b1; pending_ops.push_back(t);
    t = '0; t.op = OP_READ; t.task_index = 6'd5; pending_ops.push_back(t);

    for (int i = 0; i < 800; i++) begin
      logic [5:0] idx;
      logic [1:0] op;
      idx = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_WRITE;
        3, 4:    op = OP_SCHED;
        5, 6, 7: op = OP_TICK;
        default: op = OP_READ;
      endcase
      pending_ops.push_back(make_op(op, idx));
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data  <= '0;
      in_gap   <= $urandom_range(0, 10);
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_results.push_back(predict_result(in_data));
      if (in_gap > 0 || pending_ops.size() == 0) begin
        in_valid <= 0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_valid <= 1;
        in_data  <= pending_ops.pop_front();
        in_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected transfer", out_data, '0);
        end else if (out_data !== expected_results[0]) begin
          report("result", out_data, expected_results[0]);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
        out_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
        out_stall <= 1;
      end else if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    rst_n       = 0;
    in_valid    = 0;
    in_data     = '0;
    out_stall   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    wait (pending_ops.size() == 0);
    @(posedge clk iff (!in_valid || !in_stall));
    @(posedge clk iff expected_results.size() == 0 && !in_valid);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tsts_pkg.sv
hdl/time_slice_task_scheduler.sv
test/time_slice_task_scheduler_tb.sv
